FILE: design/rbrp_pkg.sv
// Shared types, constants and sample/byte conversion helpers for the refill pacer.
// No dependencies; compiled first.
package rbrp_pkg;

  localparam int unsigned POS_W = 16;
  localparam int unsigned WP_W  = 17;
  localparam int unsigned BUF_W = 17;
  localparam int unsigned DLV_W = 17;
  localparam int unsigned OFF_W = 16;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned CALC_W = 19;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [BUF_W-1:0] MAX_BUFFER   = 17'd65536;
  localparam int unsigned      ALIGN_BYTES  = 32;
  localparam int unsigned      SECTOR_BYTES = 2048;

  localparam logic [1:0] MODE_ADPCM = 2'd0;
  localparam logic [1:0] MODE_PCM8  = 2'd1;
  localparam logic [1:0] MODE_PCM16 = 2'd2;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_FILL = 1'b1;

  localparam logic [ST_W-1:0] ST_IDLE      = 3'd0;
  localparam logic [ST_W-1:0] ST_REQUEST   = 3'd1;
  localparam logic [ST_W-1:0] ST_POS_ERROR = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_DATA   = 3'd3;
  localparam logic [ST_W-1:0] ST_ADVANCED  = 3'd4;

  localparam logic [1:0] REG_SAMPLE_MODE = 2'd0;
  localparam logic [1:0] REG_STEREO      = 2'd1;
  localparam logic [1:0] REG_BUFFER      = 2'd2;

  typedef struct packed {
    logic [1:0]       sample_mode;
    logic             stereo;
    logic [BUF_W-1:0] buffer_bytes;
  } cfg_t;

  typedef struct packed {
    logic             opcode;
    logic [POS_W-1:0] play_position;
    logic [DLV_W-1:0] delivered_bytes;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] refill_offset;
    logic [LEN_W-1:0] refill_length;
  } result_t;

  function automatic logic [CALC_W-1:0] smp_to_bytes(input logic [1:0] mode,
                                                     input logic [CALC_W-1:0] s);
    logic [CALC_W-1:0] r;
    case (mode)
      MODE_ADPCM: r = s >> 1;
      MODE_PCM8:  r = s;
      default:    r = s << 1;
    endcase
    return r;
  endfunction

  function automatic logic [CALC_W-1:0] bytes_to_smp(input logic [1:0] mode,
                                                     input logic [CALC_W-1:0] b);
    logic [CALC_W-1:0] r;
    case (mode)
      MODE_ADPCM: r = b << 1;
      MODE_PCM8:  r = b;
      default:    r = b >> 1;
    endcase
    return r;
  endfunction

endpackage

FILE: design/rbrp_in_if.sv
// Input channel: poll or fill-completion beats with valid/ready handshake.
// Depends on rbrp_pkg.
interface rbrp_in_if import rbrp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [POS_W-1:0] play_position;
  logic [DLV_W-1:0] delivered_bytes;

  modport source(output valid, output opcode, output play_position,
                 output delivered_bytes, input ready);
  modport sink(input valid, input opcode, input play_position,
               input delivered_bytes, output ready);
endinterface

FILE: design/rbrp_res_if.sv
// Result channel: status, refill offset and length with valid/ready handshake.
// Depends on rbrp_pkg.
interface rbrp_res_if import rbrp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [OFF_W-1:0] refill_offset;
  logic [LEN_W-1:0] refill_length;

  modport source(output valid, output status, output refill_offset,
                 output refill_length, input ready);
  modport sink(input valid, input status, input refill_offset,
               input refill_length, output ready);
endinterface

FILE: design/rbrp_calc.sv
// Combinational refill decision and write-position advance for one beat.
// Depends on rbrp_pkg.
module rbrp_calc import rbrp_pkg::*; (
  input  cfg_t            cfg,
  input  item_t           item,
  input  logic [WP_W-1:0] wp,
  output result_t         res,
  output logic [WP_W-1:0] wp_nxt,
  output logic            wp_we
);

  logic [CALC_W-1:0] eff_buf;
  logic [CALC_W-1:0] half_buf;
  logic [CALC_W-1:0] pos;
  logic [CALC_W-1:0] pos_bytes;
  logic [CALC_W-1:0] align_mask;
  logic [CALC_W-1:0] pos_al;
  logic [CALC_W-1:0] wp_ext;
  logic [CALC_W-1:0] total;
  logic [CALC_W-1:0] sector_mask;
  logic [CALC_W-1:0] behind;
  logic [CALC_W-1:0] behind_bytes;
  logic [CALC_W-1:0] ahead_bytes;
  logic [CALC_W-1:0] req_bytes;
  logic [CALC_W-1:0] cap_bytes;
  logic [CALC_W-1:0] per_chan;
  logic [CALC_W-1:0] sum;
  logic [CALC_W-1:0] new_wp;
  logic [CALC_W-1:0] wp_bytes;
  logic [CALC_W-1:0] new_wp_bytes;
  logic              go;

  always_comb begin
    eff_buf    = (cfg.buffer_bytes > MAX_BUFFER) ? CALC_W'(MAX_BUFFER)
                                                 : CALC_W'(cfg.buffer_bytes);
    half_buf   = eff_buf >> 1;
    pos        = CALC_W'(item.play_position);
    pos_bytes  = smp_to_bytes(cfg.sample_mode, pos);
    align_mask = bytes_to_smp(cfg.sample_mode, CALC_W'(ALIGN_BYTES)) - CALC_W'(1);
    pos_al     = pos & ~align_mask;
    wp_ext     = CALC_W'(wp);
    total      = bytes_to_smp(cfg.sample_mode, eff_buf);
    sector_mask = bytes_to_smp(cfg.sample_mode,
                               cfg.stereo ? CALC_W'(SECTOR_BYTES / 2)
                                          : CALC_W'(SECTOR_BYTES)) - CALC_W'(1);
    behind       = (pos_al - wp_ext - CALC_W'(1)) & ~sector_mask;
    behind_bytes = smp_to_bytes(cfg.sample_mode, behind);
    ahead_bytes  = smp_to_bytes(cfg.sample_mode, total - wp_ext);
    per_chan     = cfg.stereo ? (CALC_W'(item.delivered_bytes) >> 1)
                              : CALC_W'(item.delivered_bytes);
    sum          = wp_ext + bytes_to_smp(cfg.sample_mode, per_chan);
    new_wp       = (sum >= total) ? (sum - total) : sum;
    wp_bytes     = smp_to_bytes(cfg.sample_mode, wp_ext);
    new_wp_bytes = smp_to_bytes(cfg.sample_mode, CALC_W'(new_wp[WP_W-1:0]));

    go        = 1'b0;
    req_bytes = behind_bytes;
    if (wp_ext < pos_al) begin
      go = (behind != '0) && (behind_bytes >= half_buf);
    end else if ((wp_ext > pos_al) && (wp_ext < total)) begin
      go        = 1'b1;
      req_bytes = ahead_bytes;
    end
    cap_bytes = (req_bytes > half_buf) ? half_buf : req_bytes;

    res    = '0;
    wp_we  = 1'b0;
    wp_nxt = new_wp[WP_W-1:0];
    case (item.opcode)
      OP_POLL: begin
        if (pos_bytes >= eff_buf) begin
          res.status = ST_POS_ERROR;
        end else if (go) begin
          res.status        = ST_REQUEST;
          res.refill_offset = wp_bytes[OFF_W-1:0];
          res.refill_length = cap_bytes[LEN_W-1:0];
        end else begin
          res.status = ST_IDLE;
        end
      end
      OP_FILL: begin
        if (item.delivered_bytes == '0) begin
          res.status = ST_NO_DATA;
        end else begin
          wp_we             = 1'b1;
          res.status        = ST_ADVANCED;
          res.refill_offset = new_wp_bytes[OFF_W-1:0];
        end
      end
      default: res = '0;
    endcase
  end

endmodule

FILE: design/ring_buffer_refill_pacer.sv
// Refill pacer top: APB-style register file, input beat register, result register.
// The result beat is registered after its input beat is accepted; throughput one beat per cycle
// unless out_bus.ready stalls; input ready follows adv when the input beat register is full.
// Reset (rst_n low, synchronous) empties both stages, zeroes the write position and
// loads 16-bit PCM, stereo and a 65536-byte buffer. Depends on rbrp_pkg, rbrp_calc.
module ring_buffer_refill_pacer import rbrp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rbrp_in_if.sink           in_bus,
  rbrp_res_if.source        out_bus,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t            cfg_r;
  item_t           item_r;
  logic            in_v_r;
  result_t         res_r;
  logic            out_v_r;
  logic [WP_W-1:0] wp_r;

  result_t         res;
  logic [WP_W-1:0] wp_nxt;
  logic            wp_we;
  logic            adv;
  logic            in_rdy;
  logic            cfg_wr;

  assign adv    = !out_v_r || out_bus.ready;
  assign in_rdy = !in_v_r || adv;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  assign in_bus.ready          = in_rdy;
  assign out_bus.valid         = out_v_r;
  assign out_bus.status        = res_r.status;
  assign out_bus.refill_offset = res_r.refill_offset;
  assign out_bus.refill_length = res_r.refill_length;

  rbrp_calc u_calc (
    .cfg    (cfg_r),
    .item   (item_r),
    .wp     (wp_r),
    .res    (res),
    .wp_nxt (wp_nxt),
    .wp_we  (wp_we)
  );

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_SAMPLE_MODE: prdata = DATA_W'(cfg_r.sample_mode);
      REG_STEREO:      prdata = DATA_W'(cfg_r.stereo);
      REG_BUFFER:      prdata = DATA_W'(cfg_r.buffer_bytes);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r             <= 1'b0;
      out_v_r            <= 1'b0;
      wp_r               <= '0;
      cfg_r.sample_mode  <= MODE_PCM16;
      cfg_r.stereo       <= 1'b1;
      cfg_r.buffer_bytes <= MAX_BUFFER;
    end else begin
      if (in_rdy) begin
        in_v_r <= in_bus.valid;
      end
      if (adv) begin
        out_v_r <= in_v_r;
        if (in_v_r && wp_we) begin
          wp_r <= wp_nxt;
        end
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_SAMPLE_MODE: cfg_r.sample_mode  <= pwdata[1:0];
          REG_STEREO:      cfg_r.stereo       <= pwdata[0];
          REG_BUFFER:      cfg_r.buffer_bytes <= pwdata[BUF_W-1:0];
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_bus.valid) begin
      item_r.opcode          <= in_bus.opcode;
      item_r.play_position   <= in_bus.play_position;
      item_r.delivered_bytes <= in_bus.delivered_bytes;
    end
    if (adv && in_v_r) begin
      res_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (res_r.status <= ST_ADVANCED))
    else $error("result status outside defined codes");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (res_r.status == ST_IDLE || res_r.status == ST_POS_ERROR ||
                res_r.status == ST_NO_DATA)
    |-> (res_r.refill_offset == '0 && res_r.refill_length == '0))
    else $error("offset or length set on a status without data");

  a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && in_v_r && item_r.opcode == OP_FILL) |=> $stable(wp_r))
    else $error("write position moved without a fill completion");

  a_advanced_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.status == ST_ADVANCED |-> res_r.refill_length == '0)
    else $error("advanced result carries a refill length");
`endif

endmodule
